// File: rtl/ccif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccif_pkg: shared types and constants of the configuration command framer
// Opcode values, status codes, the request descriptor passed from the
// front stage to the byte sequencer, and opcode decode functions.
// ----------------------------------------------------------------------------
package ccif_pkg;

  // Input item kinds (the op field).
  localparam logic ITEM_CMD  = 1'b0;
  localparam logic ITEM_DATA = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_ABORT = 2'd2;

  // Descriptor kinds.
  localparam logic [1:0] JOB_DATA = 2'd0;
  localparam logic [1:0] JOB_DROP = 2'd1;
  localparam logic [1:0] JOB_CMD  = 2'd2;

  // Opcodes with special framing.
  localparam logic [7:0] OPC_ERASE_UFM  = 8'h26;
  localparam logic [7:0] OPC_REFRESH    = 8'h79;
  localparam logic [7:0] OPC_ENABLE     = 8'h74;
  localparam logic [7:0] OPC_ERASE      = 8'h0e;
  localparam logic [7:0] OPC_PROG_PAGE  = 8'h70;
  localparam logic [7:0] OPC_PROG_USER  = 8'hc2;
  localparam logic [7:0] OPC_PROG_FEAT  = 8'hb4;
  localparam logic [7:0] OPC_READ_ID    = 8'he0;
  localparam logic [7:0] OPC_READ_BUSY  = 8'hf0;
  localparam logic [7:0] OPC_READ_STAT  = 8'h3c;
  localparam logic [7:0] OPC_READ_USER  = 8'hc0;
  localparam logic [7:0] OPC_READ_TRACE = 8'h19;
  localparam logic [7:0] OPC_READ_PAGE  = 8'h73;

  // Fixed operand bits.
  localparam logic [7:0] OPR_ENABLE = 8'h08;
  localparam logic [7:0] OPR_ERASE  = 8'h04;
  localparam logic [7:0] OPR_PAGE   = 8'h01;

  localparam int unsigned SHORT_WRITE_BYTES = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_val;   // data byte or opcode
    logic [6:0] waddr;      // device address captured with the request
    logic       aborted;    // command cut into a pending write
    logic       two_ops;
    logic       is_read;
    logic       is_write;
    logic [4:0] rd_cnt;
    logic [7:0] opr_first;
    logic [7:0] opr_final;
    logic       data_stop;
    logic [2:0] last_idx;   // index of the final result byte
  } job_t;

  function automatic logic is_two_ops(input logic [7:0] cmd);
    return (cmd == OPC_ERASE_UFM) || (cmd == OPC_REFRESH) || (cmd == OPC_ENABLE);
  endfunction

  function automatic logic is_read_cmd(input logic [7:0] cmd);
    return (cmd == OPC_READ_ID) || (cmd == OPC_READ_BUSY) || (cmd == OPC_READ_STAT) ||
           (cmd == OPC_READ_USER) || (cmd == OPC_READ_TRACE) || (cmd == OPC_READ_PAGE);
  endfunction

  function automatic logic is_write_cmd(input logic [7:0] cmd);
    return (cmd == OPC_PROG_PAGE) || (cmd == OPC_PROG_USER) || (cmd == OPC_PROG_FEAT);
  endfunction

  function automatic logic [4:0] read_len(input logic [7:0] cmd);
    logic [4:0] len;
    case (cmd)
      OPC_READ_ID:    len = 5'd4;
      OPC_READ_BUSY:  len = 5'd1;
      OPC_READ_STAT:  len = 5'd4;
      OPC_READ_USER:  len = 5'd4;
      OPC_READ_TRACE: len = 5'd4;
      OPC_READ_PAGE:  len = 5'd16;
      default:        len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] first_operand(input logic [7:0] cmd);
    logic [7:0] opr;
    case (cmd)
      OPC_ENABLE: opr = OPR_ENABLE;
      OPC_ERASE:  opr = OPR_ERASE;
      default:    opr = 8'h00;
    endcase
    return opr;
  endfunction

  function automatic logic [7:0] final_operand(input logic [7:0] cmd);
    return ((cmd == OPC_PROG_PAGE) || (cmd == OPC_READ_PAGE)) ? OPR_PAGE : 8'h00;
  endfunction

endpackage

// File: rtl/ccif_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccif_front: request decode and descriptor register
// Accepts input items, tracks the count of write data bytes still expected,
// and holds one decoded descriptor for the byte sequencer.
// ----------------------------------------------------------------------------
module ccif_front #(
  parameter int unsigned PAGE_BYTES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_op,
  input  logic [7:0]     in_command,
  input  logic [7:0]     in_data_byte,
  input  logic [6:0]     device_address,
  input  logic           job_take,
  output logic           job_valid,
  output ccif_pkg::job_t job
);
  import ccif_pkg::*;

  localparam int unsigned PEND_MAX =
    (PAGE_BYTES > SHORT_WRITE_BYTES) ? PAGE_BYTES : SHORT_WRITE_BYTES;
  localparam int unsigned PW = $clog2(PEND_MAX + 1);

  logic [PW-1:0] pend_r, pend_nxt;
  logic          job_valid_r, job_valid_nxt;
  job_t          job_r, job_nxt;
  logic          accept;
  logic          rd;

  assign in_stall = job_valid_r && !job_take;
  assign accept   = in_valid && !in_stall;
  assign rd       = is_read_cmd(in_command);

  always_comb begin
    job_nxt  = job_r;
    pend_nxt = pend_r;
    if (accept) begin
      job_nxt       = '0;
      job_nxt.waddr = device_address;
      if (in_op == ITEM_DATA) begin
        if (pend_r == '0) begin
          job_nxt.kind = JOB_DROP;
        end else begin
          job_nxt.kind      = JOB_DATA;
          job_nxt.byte_val  = in_data_byte;
          job_nxt.data_stop = (pend_r == PW'(1));
          pend_nxt          = pend_r - PW'(1);
        end
      end else begin
        job_nxt.kind      = JOB_CMD;
        job_nxt.byte_val  = in_command;
        job_nxt.aborted   = (pend_r != '0);
        job_nxt.two_ops   = is_two_ops(in_command);
        job_nxt.is_read   = rd;
        job_nxt.is_write  = is_write_cmd(in_command);
        job_nxt.rd_cnt    = read_len(in_command);
        job_nxt.opr_first = first_operand(in_command);
        job_nxt.opr_final = final_operand(in_command);
        // Address, opcode, operands and an optional read address byte.
        if (is_two_ops(in_command)) begin
          job_nxt.last_idx = rd ? 3'd4 : 3'd3;
        end else begin
          job_nxt.last_idx = rd ? 3'd5 : 3'd4;
        end
        if (in_command == OPC_PROG_PAGE) begin
          pend_nxt = PW'(PAGE_BYTES);
        end else if (is_write_cmd(in_command)) begin
          pend_nxt = PW'(SHORT_WRITE_BYTES);
        end else begin
          pend_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    if (accept) begin
      job_valid_nxt = 1'b1;
    end else if (job_take) begin
      job_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      job_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

// File: rtl/ccif_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccif_seq: bus byte sequencer and result register
// Walks the held descriptor into the result register one bus byte per cycle
// while out_stall does not hold it, and releases the descriptor with its final byte.
// ----------------------------------------------------------------------------
module ccif_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  ccif_pkg::job_t job,
  output logic           job_take,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_bus_byte,
  output logic           out_start_before,
  output logic           out_stop_after,
  output logic [4:0]     out_read_count,
  output logic [1:0]     out_status,
  output logic           out_last
);
  import ccif_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_bus_byte_r, out_bus_byte_nxt;
  logic       out_start_before_r, out_start_before_nxt;
  logic       out_stop_after_r, out_stop_after_nxt;
  logic [4:0] out_read_count_r, out_read_count_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic       out_last_r, out_last_nxt;
  logic       emit;
  logic [2:0] last_opr_idx;

  assign emit         = job_valid && (!out_valid_r || !out_stall);
  assign job_take     = emit && (idx_r == job.last_idx);
  assign last_opr_idx = job.two_ops ? 3'd3 : 3'd4;

  always_comb begin
    idx_nxt = idx_r;
    if (job_take) begin
      idx_nxt = 3'd0;
    end else if (emit) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_comb begin
    out_bus_byte_nxt     = 8'h00;
    out_start_before_nxt = 1'b0;
    out_stop_after_nxt   = 1'b0;
    out_read_count_nxt   = 5'd0;
    out_status_nxt       = ST_OK;
    out_last_nxt         = (idx_r == job.last_idx);
    case (job.kind)
      JOB_DATA: begin
        out_bus_byte_nxt   = job.byte_val;
        out_stop_after_nxt = job.data_stop;
      end
      JOB_DROP: begin
        out_status_nxt = ST_DROP;
      end
      JOB_CMD: begin
        out_status_nxt = job.aborted ? ST_ABORT : ST_OK;
        if (idx_r == 3'd0) begin
          out_bus_byte_nxt     = {job.waddr, 1'b0};
          out_start_before_nxt = 1'b1;
        end else if (idx_r == 3'd1) begin
          out_bus_byte_nxt = job.byte_val;
        end else if (idx_r <= last_opr_idx) begin
          if (idx_r == 3'd2) begin
            out_bus_byte_nxt = job.opr_first;
          end else if (idx_r == last_opr_idx) begin
            out_bus_byte_nxt = job.opr_final;
          end
          out_stop_after_nxt = (idx_r == last_opr_idx) && !job.is_read && !job.is_write;
        end else begin
          // Repeated start with the read address; the stop follows the read.
          out_bus_byte_nxt     = {job.waddr, 1'b1};
          out_start_before_nxt = 1'b1;
          out_stop_after_nxt   = 1'b1;
          out_read_count_nxt   = job.rd_cnt;
        end
      end
      default: begin
        out_status_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_bus_byte_r     <= out_bus_byte_nxt;
      out_start_before_r <= out_start_before_nxt;
      out_stop_after_r   <= out_stop_after_nxt;
      out_read_count_r   <= out_read_count_nxt;
      out_status_r       <= out_status_nxt;
      out_last_r         <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bus_byte     = out_bus_byte_r;
  assign out_start_before = out_start_before_r;
  assign out_stop_after   = out_stop_after_r;
  assign out_read_count   = out_read_count_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  a_idx_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !job_valid |-> idx_r == 3'd0)
    else $error("byte index moved without a held request");

  a_idx_bound : assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> idx_r <= job.last_idx)
    else $error("byte index ran past the final byte of the request");

  a_read_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_start_before_r && out_stop_after_r |-> out_read_count_r != 5'd0)
    else $error("read address byte carries no read count");

  a_drop_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_DROP) |-> out_last_r && !out_start_before_r)
    else $error("dropped data byte result is not a single final byte");

  a_take_emit : assert property (@(posedge clk) disable iff (!rst_n)
    job_take |=> out_valid_r && out_last_r)
    else $error("request released without its final byte in the result register");

endmodule

// File: rtl/config_command_i2c_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_command_i2c_framer: I2C byte framer for configuration commands
// Turns command and write data requests into bus bytes with start, stop
// and read count markers for a byte-level I2C master.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request: a command
//   opcode (in_op = 0) or a write data byte (in_op = 1). Result channel
//   (out_valid / out_stall) gives one bus byte per transfer; out_last marks
//   the final byte of each request.
//   A command request yields 4 to 6 bytes, a data request exactly one.
//   Bytes leave the sequencer one per cycle while out_stall allows, so a
//   command holds the input until its final byte leaves, and data requests
//   flow at one per cycle. The first result byte of a request passes the
//   descriptor register, then the result register.
//   While out_stall is high the result register holds, and one further
//   request is taken into the descriptor register before in_stall rises.
//   The cfg port writes the 7-bit device address; cfg_ready is always high.
//   Write it only while no request is in flight.
//   Synchronous reset sets the device address to 0x40, clears the count of
//   expected write data bytes and empties both registers.
// ----------------------------------------------------------------------------
module config_command_i2c_framer #(
  parameter int unsigned PAGE_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_device_address,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_command,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_bus_byte,
  output logic       out_start_before,
  output logic       out_stop_after,
  output logic [4:0] out_read_count,
  output logic [1:0] out_status,
  output logic       out_last
);
  import ccif_pkg::*;

  localparam logic [6:0] DEV_ADDR_RESET = 7'h40;

  logic [6:0] dev_addr_r, dev_addr_nxt;
  logic       job_valid;
  logic       job_take;
  job_t       job;

  assign cfg_ready    = 1'b1;
  assign dev_addr_nxt = (cfg_valid && cfg_ready) ? cfg_device_address : dev_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  ccif_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_command    (in_command),
    .in_data_byte  (in_data_byte),
    .device_address(dev_addr_r),
    .job_take      (job_take),
    .job_valid     (job_valid),
    .job           (job)
  );

  ccif_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job             (job),
    .job_take        (job_take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bus_byte    (out_bus_byte),
    .out_start_before(out_start_before),
    .out_stop_after  (out_stop_after),
    .out_read_count  (out_read_count),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

// File: test/config_command_i2c_framer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// config_command_i2c_framer_test: self-checking bench for the command framer
// Sends command and write data requests, predicts every bus byte with a
// behavioral framer kept in step with the block, and checks each result in
// order. Runs directed cases first, then random request streams under
// several idling patterns and device addresses.
// ----------------------------------------------------------------------------
module config_command_i2c_framer_test;
  import ccif_pkg::*;

  localparam int unsigned PAGE_LEN = 16;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic [4:0] read_count;
    logic [1:0] status;
    logic       last;
  } bus_byte_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [6:0] cfg_device_address;
  logic       in_valid;
  logic       in_stall;
  logic       in_op;
  logic [7:0] in_command;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_bus_byte;
  logic       out_start_before;
  logic       out_stop_after;
  logic [4:0] out_read_count;
  logic [1:0] out_status;
  logic       out_last;

  // Behavioral copy of the framer state.
  logic [6:0] target_addr;
  logic [6:0] page_bytes_left;
  bus_byte_t  bus_bytes_due[$];

  int mismatches;
  int items_sent;
  int send_idle_pct;
  int stall_pct;

  config_command_i2c_framer #(
    .PAGE_BYTES(PAGE_LEN)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_device_address(cfg_device_address),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_command        (in_command),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bus_byte      (out_bus_byte),
    .out_start_before  (out_start_before),
    .out_stop_after    (out_stop_after),
    .out_read_count    (out_read_count),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  function automatic bus_byte_t bus_entry(input logic [7:0] val, input logic start,
                                          input logic stop, input logic [4:0] rcount,
                                          input logic [1:0] st);
    bus_byte_t b;
    b.bus_byte     = val;
    b.start_before = start;
    b.stop_after   = stop;
    b.read_count   = rcount;
    b.status       = st;
    b.last         = 1'b0;
    return b;
  endfunction

  // Works out the bus bytes that one accepted request produces.
  task automatic frame_request(input logic op, input logic [7:0] cmd, input logic [7:0] dat);
    bus_byte_t  run[$];
    logic [1:0] st;
    logic [7:0] waddr;
    logic [7:0] oprs [3];
    int         nops;
    logic [4:0] rlen;
    logic [6:0] wlen;
    logic       is_rd;
    logic       is_wr;
    if (op == ITEM_DATA) begin
      if (page_bytes_left == 0) begin
        run.push_back(bus_entry(8'h00, 1'b0, 1'b0, 5'd0, ST_DROP));
      end else begin
        page_bytes_left = page_bytes_left - 7'd1;
        run.push_back(bus_entry(dat, 1'b0, page_bytes_left == 0, 5'd0, ST_OK));
      end
    end else begin
      st = (page_bytes_left != 0) ? ST_ABORT : ST_OK;
      waddr = {target_addr, 1'b0};
      nops = (cmd == OPC_ERASE_UFM || cmd == OPC_REFRESH || cmd == OPC_ENABLE) ? 2 : 3;
      oprs[0] = 8'h00;
      oprs[1] = 8'h00;
      oprs[2] = 8'h00;
      if (cmd == OPC_ENABLE) oprs[0] = OPR_ENABLE;
      if (cmd == OPC_ERASE) oprs[0] = OPR_ERASE;
      if (cmd == OPC_PROG_PAGE || cmd == OPC_READ_PAGE) oprs[2] = OPR_PAGE;
      case (cmd)
        OPC_READ_ID, OPC_READ_STAT, OPC_READ_USER, OPC_READ_TRACE: rlen = 5'd4;
        OPC_READ_BUSY: rlen = 5'd1;
        OPC_READ_PAGE: rlen = 5'd16;
        default:       rlen = 5'd0;
      endcase
      case (cmd)
        OPC_PROG_PAGE:                wlen = 7'(PAGE_LEN);
        OPC_PROG_USER, OPC_PROG_FEAT: wlen = 7'd4;
        default:                      wlen = 7'd0;
      endcase
      is_rd = (rlen != 0);
      is_wr = (wlen != 0);
      run.push_back(bus_entry(waddr, 1'b1, 1'b0, 5'd0, st));
      run.push_back(bus_entry(cmd, 1'b0, 1'b0, 5'd0, st));
      for (int i = 0; i < nops; i++) begin
        run.push_back(bus_entry(oprs[i], 1'b0, (i == nops - 1) && !is_rd && !is_wr,
                                5'd0, st));
      end
      // The read address byte also carries the stop that ends the read.
      if (is_rd) run.push_back(bus_entry(waddr | 8'h01, 1'b1, 1'b1, rlen, st));
      page_bytes_left = wlen;
    end
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) bus_bytes_due.push_back(run[i]);
  endtask

  task automatic report_mismatch(input string what, input bus_byte_t want,
                                 input bus_byte_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected byte=%02h start=%0b stop=%0b rcount=%0d status=%0d last=%0b",
               $realtime, what, want.bus_byte, want.start_before, want.stop_after,
               want.read_count, want.status, want.last);
      $display("%0t: %s: actual   byte=%02h start=%0b stop=%0b rcount=%0d status=%0d last=%0b",
               $realtime, what, got.bus_byte, got.start_before, got.stop_after,
               got.read_count, got.status, got.last);
    end
  endtask

  always @(posedge clk) begin
    bus_byte_t got;
    bus_byte_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_bus_byte, out_start_before, out_stop_after, out_read_count,
              out_status, out_last};
      if (bus_bytes_due.size() == 0) begin
        report_mismatch("result with nothing expected", '0, got);
      end else begin
        want = bus_bytes_due.pop_front();
        if (got.bus_byte !== want.bus_byte || got.start_before !== want.start_before ||
            got.stop_after !== want.stop_after || got.read_count !== want.read_count ||
            got.status !== want.status || got.last !== want.last) begin
          report_mismatch("wrong result", want, got);
        end
      end
    end
  end

  // Entered and left at a falling edge.
  task automatic send_request(input logic op, input logic [7:0] cmd, input logic [7:0] dat);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_op        = op;
    in_command   = cmd;
    in_data_byte = dat;
    in_valid     = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    frame_request(op, cmd, dat);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_command(input logic [7:0] cmd);
    send_request(ITEM_CMD, cmd, 8'($urandom_range(255)));
  endtask

  task automatic send_data(input logic [7:0] dat);
    send_request(ITEM_DATA, 8'($urandom_range(255)), dat);
  endtask

  task automatic wait_results_done();
    in_valid = 1'b0;
    while (bus_bytes_due.size() != 0) @(posedge clk);
    // Margin for the descriptor and result registers to empty.
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_device_address(input logic [6:0] addr);
    cfg_device_address = addr;
    cfg_valid          = 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    target_addr = addr;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly complete command sequences, with stray and cut-short data mixed in.
  task automatic random_requests(input int count);
    int         stop_at;
    int         pick;
    int         len;
    logic [7:0] cmd;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        case ($urandom_range(2))
          0:       cmd = OPC_PROG_PAGE;
          1:       cmd = OPC_PROG_USER;
          default: cmd = OPC_PROG_FEAT;
        endcase
        len = (cmd == OPC_PROG_PAGE) ? PAGE_LEN : SHORT_WRITE_BYTES;
        if ($urandom_range(9) == 0) len = $urandom_range(0, len - 1);
        send_command(cmd);
        repeat (len) send_data(8'($urandom_range(255)));
      end else if (pick < 70) begin
        case ($urandom_range(5))
          0:       cmd = OPC_READ_ID;
          1:       cmd = OPC_READ_BUSY;
          2:       cmd = OPC_READ_STAT;
          3:       cmd = OPC_READ_USER;
          4:       cmd = OPC_READ_TRACE;
          default: cmd = OPC_READ_PAGE;
        endcase
        send_command(cmd);
      end else if (pick < 88) begin
        case ($urandom_range(4))
          0:       cmd = OPC_ERASE_UFM;
          1:       cmd = OPC_REFRESH;
          2:       cmd = OPC_ENABLE;
          3:       cmd = OPC_ERASE;
          default: cmd = 8'($urandom_range(255));
        endcase
        send_command(cmd);
      end else begin
        send_data(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_command(OPC_ENABLE);
    send_command(OPC_ERASE);
    send_command(OPC_ERASE_UFM);
    send_command(OPC_REFRESH);
    send_command(OPC_READ_ID);
    send_command(OPC_READ_BUSY);
    send_command(OPC_READ_STAT);
    send_command(OPC_READ_USER);
    send_command(OPC_READ_TRACE);
    send_command(OPC_READ_PAGE);
    send_command(OPC_PROG_USER);
    send_data(8'h00);
    send_data(8'hff);
    send_data(8'ha5);
    send_data(8'h5a);
    // A data byte with no write open is dropped.
    send_data(8'hff);
    // A command cutting into an open write is flagged, then framed.
    send_command(OPC_PROG_FEAT);
    send_data(8'h3c);
    send_data(8'hc3);
    send_command(OPC_READ_PAGE);
    send_command(8'h00);
    send_command(8'hff);
    wait_results_done();
  endtask

  task automatic test_streaming();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_device_address(7'h00);
    random_requests(110);
    wait_results_done();
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 69;
    stall_pct     = 0;
    write_device_address(7'h7f);
    random_requests(110);
    wait_results_done();
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    stall_pct     = 69;
    write_device_address(7'($urandom_range(127)));
    random_requests(110);
    wait_results_done();
  endtask

  task automatic test_mixed_idling();
    send_idle_pct = 26;
    stall_pct     = 26;
    write_device_address(7'($urandom_range(127)));
    random_requests(60);
    // Hold off until the block has delivered everything, then resume.
    in_valid = 1'b0;
    while (bus_bytes_due.size() != 0) @(negedge clk);
    random_requests(60);
    wait_results_done();
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_valid          = 1'b0;
    cfg_device_address = 7'h00;
    in_valid           = 1'b0;
    in_op              = ITEM_CMD;
    in_command         = 8'h00;
    in_data_byte       = 8'h00;
    out_stall          = 1'b0;
    send_idle_pct      = 0;
    stall_pct          = 0;
    mismatches         = 0;
    items_sent         = 0;
    target_addr        = 7'h40;
    page_bytes_left    = 7'd0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();

    mismatches += bus_bytes_due.size();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
